// ===== rtl/core/oriented_box_overlap_test_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the oriented box overlap test unit
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_OVERLAP_TEST_UNIT_ASSERT_SVH
`define ORIENTED_BOX_OVERLAP_TEST_UNIT_ASSERT_SVH

// assertion that is switched off while reset is high
`define OBBT_ASSERT_RST(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// assertion that also holds across reset
`define OBBT_ASSERT(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/core/obbt_pkg.sv =====
// ----------------------------------------------------------------------------
// obbt_pkg
// Shared constants of the oriented box overlap test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package obbt_pkg;

  // width of every coordinate field on the ports
  localparam int FIELD_WIDTH = 32;

  // edges per pair: first u, first v, second u, second v
  localparam int NUM_EDGES = 4;

  // register stages inside the split multiplier
  localparam int MUL_LATENCY = 2;

  // input reg, multiplier, dot sum, magnitude, extent sum, compare
  localparam int PIPE_LATENCY = 1 + MUL_LATENCY + 4;

endpackage

`default_nettype wire

// ===== rtl/core/obbt_mul.sv =====
// ----------------------------------------------------------------------------
// obbt_mul
// Two-stage signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module obbt_mul #(
  parameter int OPER_WIDTH = 33
) (
  input  wire logic                          clk,
  input  wire logic signed [OPER_WIDTH-1:0]  a,
  input  wire logic signed [OPER_WIDTH-1:0]  b,
  output logic signed [2*OPER_WIDTH-1:0]     p
);

  localparam int LO_W = (OPER_WIDTH + 1) / 2;
  localparam int HI_W = OPER_WIDTH - LO_W;
  localparam int PW   = 2 * OPER_WIDTH;

  logic signed [HI_W-1:0]   a_hi;
  logic signed [HI_W-1:0]   b_hi;
  logic signed [LO_W:0]     a_lo;
  logic signed [LO_W:0]     b_lo;

  logic signed [2*HI_W-1:0]      pp_hh;
  logic signed [HI_W+LO_W:0]     pp_hl;
  logic signed [HI_W+LO_W:0]     pp_lh;
  logic signed [2*LO_W+1:0]      pp_ll;

  // low halves are unsigned, carried with a zero sign bit
  assign a_hi = a[OPER_WIDTH-1:LO_W];
  assign b_hi = b[OPER_WIDTH-1:LO_W];
  assign a_lo = {1'b0, a[LO_W-1:0]};
  assign b_lo = {1'b0, b[LO_W-1:0]};

  always_ff @(posedge clk) begin
    pp_hh <= a_hi * b_hi;
    pp_hl <= a_hi * b_lo;
    pp_lh <= a_lo * b_hi;
    pp_ll <= a_lo * b_lo;
  end

  always_ff @(posedge clk) begin
    p <= (PW'(pp_hh) <<< (2 * LO_W)) + (PW'(pp_hl) <<< LO_W)
       + (PW'(pp_lh) <<< LO_W) + PW'(pp_ll);
  end

endmodule

`default_nettype wire

// ===== rtl/core/oriented_box_overlap_test_unit.sv =====
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_unit
// Separating axis overlap test of two oriented rectangles in Q16.16.
// ----------------------------------------------------------------------------
// One box pair is taken on every cycle in which start is high and busy is
// low; busy is high only while rst is asserted. Each pair yields one beat:
// done pulses for one cycle with boxes_overlap once the pair has passed
// the pipeline, and results leave in the order the pairs came in. The
// receiver cannot hold a beat off, so it must sample done when it pulses.
// Latency is set by the pipeline: input register, the two-stage split
// multipliers, dot sum, magnitude, extent sum and the final compare.
// Sustained rate is one pair per cycle while busy is low. Touching boxes
// count as overlapping, and a zero-length edge never separates.
`default_nettype none

module oriented_box_overlap_test_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      first_center_x,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      first_center_y,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      first_edge_u_x,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      first_edge_u_y,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      first_edge_v_x,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      first_edge_v_y,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      second_center_x,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      second_center_y,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      second_edge_u_x,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      second_edge_u_y,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      second_edge_v_x,
  input  wire logic [obbt_pkg::FIELD_WIDTH-1:0]      second_edge_v_y,
  output logic                                       done,
  output logic                                       boxes_overlap
);

  import obbt_pkg::*;

  localparam int XW   = (COORD_WIDTH > FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;
  localparam int OW   = COORD_WIDTH + 1;  // operand width, fits the centre offset
  localparam int PW   = 2 * OW;           // product
  localparam int DW   = PW + 1;           // dot product, and its magnitude
  localparam int SW   = DW + 2;           // sum of four magnitudes
  localparam int NOPS = NUM_EDGES + 1;    // every edge and the centre offset

  // low COORD_WIDTH bits of a field, sign-extended from there
  function automatic logic signed [COORD_WIDTH-1:0] take(
    input logic [FIELD_WIDTH-1:0] f
  );
    logic signed [XW-1:0] w;
    w = XW'(f);
    return w[COORD_WIDTH-1:0];
  endfunction

  function automatic logic signed [OW-1:0] widen(input logic [FIELD_WIDTH-1:0] f);
    return OW'(take(f));
  endfunction

  logic                  accept;
  logic [PIPE_LATENCY-1:0] vld;

  logic signed [OW-1:0]  op_x [NOPS];
  logic signed [OW-1:0]  op_y [NOPS];

  logic signed [PW-1:0]  prod_x [NUM_EDGES][NOPS];
  logic signed [PW-1:0]  prod_y [NUM_EDGES][NOPS];
  logic signed [DW-1:0]  dot    [NUM_EDGES][NOPS];
  logic        [DW-1:0]  mag    [NUM_EDGES][NOPS];
  logic        [SW-1:0]  extent [NUM_EDGES];
  logic        [DW:0]    cp2    [NUM_EDGES];
  logic [NUM_EDGES-1:0]  sep;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[PIPE_LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LATENCY-2:0], accept};
    end
  end

  // input stage: edges and centre offset, all at operand width
  always_ff @(posedge clk) begin
    op_x[0] <= widen(first_edge_u_x);
    op_y[0] <= widen(first_edge_u_y);
    op_x[1] <= widen(first_edge_v_x);
    op_y[1] <= widen(first_edge_v_y);
    op_x[2] <= widen(second_edge_u_x);
    op_y[2] <= widen(second_edge_u_y);
    op_x[3] <= widen(second_edge_v_x);
    op_y[3] <= widen(second_edge_v_y);
    op_x[NUM_EDGES] <= widen(second_center_x) - widen(first_center_x);
    op_y[NUM_EDGES] <= widen(second_center_y) - widen(first_center_y);
  end

  // axis i against every edge and the centre offset
  for (genvar i = 0; i < NUM_EDGES; i++) begin : g_axis
    for (genvar j = 0; j < NOPS; j++) begin : g_term
      obbt_mul #(.OPER_WIDTH(OW)) u_mul_x (
        .clk (clk),
        .a   (op_x[j]),
        .b   (op_x[i]),
        .p   (prod_x[i][j])
      );
      obbt_mul #(.OPER_WIDTH(OW)) u_mul_y (
        .clk (clk),
        .a   (op_y[j]),
        .b   (op_y[i]),
        .p   (prod_y[i][j])
      );

      always_ff @(posedge clk) begin
        dot[i][j] <= DW'(prod_x[i][j]) + DW'(prod_y[i][j]);
      end

      // most negative dot maps to its true magnitude as unsigned
      always_ff @(posedge clk) begin
        mag[i][j] <= dot[i][j][DW-1] ? DW'(-dot[i][j]) : DW'(dot[i][j]);
      end
    end

    always_ff @(posedge clk) begin
      extent[i] <= (SW'(mag[i][0]) + SW'(mag[i][1]))
                 + (SW'(mag[i][2]) + SW'(mag[i][3]));
      cp2[i]    <= {mag[i][NUM_EDGES], 1'b0};
    end

    assign sep[i] = extent[i] < SW'(cp2[i]);
  end

  always_ff @(posedge clk) begin
    boxes_overlap <= ~|sep;
  end

endmodule

`default_nettype wire

// ===== rtl/core/obbt_checker.sv =====
// ----------------------------------------------------------------------------
// obbt_checker
// Port-level timing checks of the overlap test unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "oriented_box_overlap_test_unit_assert.svh"

module obbt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic boxes_overlap
);

  import obbt_pkg::*;

  // every taken pair comes back after the fixed latency
  `OBBT_ASSERT_RST(a_pair_returns, clk, rst, (start && !busy) |-> ##PIPE_LATENCY done, "pair lost")

  // no beat without a pair taken one latency earlier
  `OBBT_ASSERT_RST(a_no_stray_beat, clk, rst, done |-> $past(start && !busy, PIPE_LATENCY), "stray beat")

  // the pipeline is empty right after reset
  `OBBT_ASSERT(a_empty_after_rst, clk, $past(rst) |-> !done, "beat after reset")

  // a beat carries a known result
  `OBBT_ASSERT_RST(a_known_result, clk, rst, done |-> !$isunknown(boxes_overlap), "unknown result")

endmodule

bind oriented_box_overlap_test_unit obbt_checker u_obbt_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .boxes_overlap (boxes_overlap)
);

`default_nettype wire
